// ----- design/rpc_pkg.sv -----
package rpc_pkg;

  // Field widths of the request and result channels.
  localparam int SAMPLE_W = 24;
  localparam int N_W      = 11;
  localparam int CORR_W   = 16;

  // Running sums are sized for the widest window the 11-bit register can name.
  localparam int SUM_W  = SAMPLE_W + N_W;
  localparam int SQ_W   = 2 * SAMPLE_W + N_W;
  localparam int SP_W   = 2 * SAMPLE_W;

  // Centred moments and their products.
  localparam int V_W    = N_W + SQ_W;
  localparam int PROD_W = 2 * V_W;
  localparam int DIG_W  = 18;
  localparam int NDIG   = (V_W + DIG_W - 1) / DIG_W;

  // Quotient of the ratio test and its square root.
  localparam int Q_W    = 33;
  localparam int ROOT_W = 17;

  // Defaults.
  localparam int MAX_WINDOW_DEF = 1024;
  localparam int WINDOW_RESET   = 20;
  localparam int FIFO_DEPTH     = 2;

  // One full window handed from the front to the back.
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_b;
    logic [SQ_W-1:0]  sum_aa;
    logic [SQ_W-1:0]  sum_bb;
    logic [SQ_W-1:0]  sum_ab;
  } rpc_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } rpc_q_stat_t;

endpackage

// ----- design/rpc_ram.sv -----
module rpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rpc_fifo.sv -----
module rpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output rpc_pkg::rpc_q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign do_push    = push && (count_r != CW'(DEPTH));
  assign do_pop     = pop && (count_r != '0);
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = slot_r[rptr_r];

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (32'(wptr_r) == DEPTH - 1) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (32'(rptr_r) == DEPTH - 1) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/rpc_front.sv -----
module rpc_front #(
  parameter int MAX_WINDOW = rpc_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rpc_pkg::N_W-1:0]     cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpc_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic [rpc_pkg::SAMPLE_W-1:0] in_sample_b,
  input  rpc_pkg::rpc_q_stat_t        q_stat,
  output logic                        q_push,
  output rpc_pkg::rpc_job_t           q_job
);

  import rpc_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC,
    F_PUSH
  } fstate_t;

  fstate_t                 state_r;
  logic [N_W-1:0]          win_r;
  logic [N_W-1:0]          n_eff;
  logic [N_W-1:0]          fill_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [SAMPLE_W-1:0]     a_r;
  logic [SAMPLE_W-1:0]     b_r;
  logic [2*SAMPLE_W-1:0]   old_rd;
  logic [SAMPLE_W-1:0]     oa;
  logic [SAMPLE_W-1:0]     ob;
  logic [SAMPLE_W-1:0]     oa_r;
  logic [SAMPLE_W-1:0]     ob_r;
  logic [SP_W-1:0]         aa_r;
  logic [SP_W-1:0]         bb_r;
  logic [SP_W-1:0]         ab_r;
  logic [SP_W-1:0]         oaa_r;
  logic [SP_W-1:0]         obb_r;
  logic [SP_W-1:0]         oab_r;
  logic [SUM_W-1:0]        sum_a_r;
  logic [SUM_W-1:0]        sum_b_r;
  logic [SQ_W-1:0]         sum_aa_r;
  logic [SQ_W-1:0]         sum_bb_r;
  logic [SQ_W-1:0]         sum_ab_r;
  logic                    full;
  logic                    ring_we;
  logic [N_W-1:0]          fill_nxt;

  // Window length as used: clamped to at least 2 and at most the ring size.
  always_comb begin
    if (win_r < N_W'(2)) begin
      n_eff = N_W'(2);
    end else if (32'(win_r) > MAX_WINDOW) begin
      n_eff = N_W'(MAX_WINDOW);
    end else begin
      n_eff = win_r;
    end
  end

  assign full     = (fill_r >= n_eff);
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;
  assign ring_we  = (state_r == F_ACC);
  assign in_ready = (state_r == F_IDLE);
  assign oa       = old_rd[2*SAMPLE_W-1:SAMPLE_W];
  assign ob       = old_rd[SAMPLE_W-1:0];

  // Ring of the most recent pairs; the slot under the pointer holds the oldest.
  rpc_ram #(
    .WIDTH(2 * SAMPLE_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ptr_r),
    .wdata({a_r, b_r}),
    .raddr(ptr_r),
    .rdata(old_rd)
  );

  assign q_push       = (state_r == F_PUSH) && !q_stat.full;
  assign q_job.n      = n_eff;
  assign q_job.sum_a  = sum_a_r;
  assign q_job.sum_b  = sum_b_r;
  assign q_job.sum_aa = sum_aa_r;
  assign q_job.sum_bb = sum_bb_r;
  assign q_job.sum_ab = sum_ab_r;

  // Request capture and registered products; no reset on payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_r <= in_sample_a;
      b_r <= in_sample_b;
    end
    if (state_r == F_MUL) begin
      oa_r  <= oa;
      ob_r  <= ob;
      aa_r  <= a_r * a_r;
      bb_r  <= b_r * b_r;
      ab_r  <= a_r * b_r;
      oaa_r <= oa * oa;
      obb_r <= ob * ob;
      oab_r <= oa * ob;
    end
  end

  // Sequencer, running sums, fill count and ring pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      win_r    <= N_W'(WINDOW_RESET);
      fill_r   <= '0;
      ptr_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      sum_aa_r <= '0;
      sum_bb_r <= '0;
      sum_ab_r <= '0;
    end else if (cfg_we) begin
      win_r    <= cfg_wdata;
      fill_r   <= '0;
      ptr_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      sum_aa_r <= '0;
      sum_bb_r <= '0;
      sum_ab_r <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          state_r <= F_ACC;
        end
        F_ACC: begin
          // Drop the oldest pair once the window is full, then add the new one.
          if (full) begin
            sum_a_r  <= sum_a_r + SUM_W'(a_r) - SUM_W'(oa_r);
            sum_b_r  <= sum_b_r + SUM_W'(b_r) - SUM_W'(ob_r);
            sum_aa_r <= sum_aa_r + SQ_W'(aa_r) - SQ_W'(oaa_r);
            sum_bb_r <= sum_bb_r + SQ_W'(bb_r) - SQ_W'(obb_r);
            sum_ab_r <= sum_ab_r + SQ_W'(ab_r) - SQ_W'(oab_r);
          end else begin
            sum_a_r  <= sum_a_r + SUM_W'(a_r);
            sum_b_r  <= sum_b_r + SUM_W'(b_r);
            sum_aa_r <= sum_aa_r + SQ_W'(aa_r);
            sum_bb_r <= sum_bb_r + SQ_W'(bb_r);
            sum_ab_r <= sum_ab_r + SQ_W'(ab_r);
          end
          fill_r <= fill_nxt;
          ptr_r  <= (32'(ptr_r) + 1 == 32'(n_eff)) ? '0 : ptr_r + 1'b1;
          state_r <= (fill_nxt >= n_eff) ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/rpc_back.sv -----
module rpc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpc_pkg::rpc_q_stat_t      q_stat,
  input  rpc_pkg::rpc_job_t         q_job,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rpc_pkg::CORR_W-1:0] out_correlation,
  output logic                      out_degenerate
);

  import rpc_pkg::*;

  localparam int DGI_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(Q_W);
  localparam int SRC_W = 2 * ROOT_W;
  localparam int SRM_W = ROOT_W + 1;
  localparam int SSH_W = SRM_W + 2;
  localparam int REM_W = PROD_W + 1;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_POST,
    B_DIV,
    B_SQRT,
    B_OUT
  } bstate_t;

  // Order of the products taken on the shared multiplier.
  typedef enum logic [2:0] {
    OP_NSAA,
    OP_SASA,
    OP_NSBB,
    OP_SBSB,
    OP_NSAB,
    OP_SASB,
    OP_VAVB,
    OP_CC
  } op_t;

  bstate_t             state_r;
  op_t                 op_r;
  rpc_job_t            job_r;
  logic [V_W-1:0]      ma_r;
  logic [NDIG*DIG_W-1:0] mb_r;
  logic [DGI_W-1:0]    dig_r;
  logic [DGI_W-1:0]    last_r;
  logic [PROD_W-1:0]   acc_r;
  logic [PROD_W-1:0]   acc_nxt;
  logic [V_W+DIG_W-1:0] pp;
  logic [V_W-1:0]      acc_lo;
  logic [V_W-1:0]      t_r;
  logic [V_W-1:0]      va_r;
  logic [V_W-1:0]      vb_r;
  logic [V_W-1:0]      cmag_r;
  logic                neg_r;
  logic                deg_r;
  logic [PROD_W-1:0]   p_r;
  logic [REM_W-1:0]    rem_r;
  logic [REM_W-1:0]    cur;
  logic                div_ge;
  logic [Q_W-1:0]      q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SRC_W-1:0]    src_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SRM_W-1:0]    srem_r;
  logic [SSH_W-1:0]    srem_sh;
  logic [SSH_W-1:0]    trial;
  logic                sq_ge;
  logic [ROOT_W:0]     m_wide;
  logic [CORR_W-1:0]   m16;
  logic [CORR_W-1:0]   corr;
  logic                out_valid_r;
  logic [CORR_W-1:0]   corr_r;
  logic                outdeg_r;
  logic                out_free;

  // One digit of the second operand per cycle into the accumulator.
  assign pp      = ma_r * mb_r[DIG_W*dig_r +: DIG_W];
  assign acc_nxt = acc_r + (PROD_W'(pp) << (DIG_W * dig_r));
  assign acc_lo  = acc_r[V_W-1:0];

  // Restoring division step: quotient of C squared times 2^32 over Va times Vb.
  assign cur    = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign div_ge = (cur >= {1'b0, p_r});

  // Square root step: two radicand bits in, one root bit out a step.
  assign srem_sh = {srem_r, src_r[SRC_W-1:SRC_W-2]};
  assign trial   = SSH_W'({root_r, 2'b01});
  assign sq_ge   = (srem_sh >= trial);

  // Round half away from zero: the largest m with (2m-1) not above the root.
  assign m_wide = ({1'b0, root_r} + 1'b1) >> 1;
  assign m16    = m_wide[CORR_W-1:0];
  always_comb begin
    if (deg_r) begin
      corr = '0;
    end else if (neg_r) begin
      corr = CORR_W'(~m16 + 1'b1);
    end else if (m_wide > (ROOT_W+1)'(2**(CORR_W-1) - 1)) begin
      corr = CORR_W'(2**(CORR_W-1) - 1);
    end else begin
      corr = m16;
    end
  end

  assign out_free        = !out_valid_r || out_ready;
  assign q_pop           = (state_r == B_IDLE) && !q_stat.empty;
  assign out_valid       = out_valid_r;
  assign out_correlation = corr_r;
  assign out_degenerate  = outdeg_r;

  // Sequencer with its datapath registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            job_r   <= q_job;
            op_r    <= OP_NSAA;
            ma_r    <= V_W'(q_job.sum_aa);
            mb_r    <= (NDIG*DIG_W)'(q_job.n);
            dig_r   <= '0;
            last_r  <= '0;
            acc_r   <= '0;
            deg_r   <= 1'b0;
            neg_r   <= 1'b0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          acc_r <= acc_nxt;
          dig_r <= dig_r + 1'b1;
          if (dig_r == last_r) begin
            state_r <= B_POST;
          end
        end
        B_POST: begin
          acc_r   <= '0;
          dig_r   <= '0;
          case (op_r)
            OP_NSAA: begin
              t_r     <= acc_lo;
              ma_r    <= V_W'(job_r.sum_a);
              mb_r    <= (NDIG*DIG_W)'(job_r.sum_a);
              last_r  <= DGI_W'(1);
              op_r    <= OP_SASA;
              state_r <= B_MUL;
            end
            OP_SASA: begin
              va_r    <= t_r - acc_lo;
              ma_r    <= V_W'(job_r.sum_bb);
              mb_r    <= (NDIG*DIG_W)'(job_r.n);
              last_r  <= '0;
              op_r    <= OP_NSBB;
              state_r <= B_MUL;
            end
            OP_NSBB: begin
              t_r     <= acc_lo;
              ma_r    <= V_W'(job_r.sum_b);
              mb_r    <= (NDIG*DIG_W)'(job_r.sum_b);
              last_r  <= DGI_W'(1);
              op_r    <= OP_SBSB;
              state_r <= B_MUL;
            end
            OP_SBSB: begin
              vb_r    <= t_r - acc_lo;
              ma_r    <= V_W'(job_r.sum_ab);
              mb_r    <= (NDIG*DIG_W)'(job_r.n);
              last_r  <= '0;
              op_r    <= OP_NSAB;
              state_r <= B_MUL;
            end
            OP_NSAB: begin
              t_r     <= acc_lo;
              ma_r    <= V_W'(job_r.sum_a);
              mb_r    <= (NDIG*DIG_W)'(job_r.sum_b);
              last_r  <= DGI_W'(1);
              op_r    <= OP_SASB;
              state_r <= B_MUL;
            end
            OP_SASB: begin
              // Covariance as magnitude and sign.
              if (t_r >= acc_lo) begin
                cmag_r <= t_r - acc_lo;
                neg_r  <= 1'b0;
              end else begin
                cmag_r <= acc_lo - t_r;
                neg_r  <= 1'b1;
              end
              ma_r   <= va_r;
              mb_r   <= (NDIG*DIG_W)'(vb_r);
              last_r <= DGI_W'(NDIG - 1);
              op_r   <= OP_VAVB;
              // A flat series has no correlation.
              if (va_r == '0 || vb_r == '0) begin
                deg_r   <= 1'b1;
                state_r <= B_OUT;
              end else begin
                state_r <= B_MUL;
              end
            end
            OP_VAVB: begin
              p_r     <= acc_r;
              ma_r    <= cmag_r;
              mb_r    <= (NDIG*DIG_W)'(cmag_r);
              last_r  <= DGI_W'(NDIG - 1);
              op_r    <= OP_CC;
              state_r <= B_MUL;
            end
            OP_CC: begin
              rem_r   <= REM_W'(acc_r);
              cnt_r   <= '0;
              state_r <= B_DIV;
            end
            default: begin
              state_r <= B_IDLE;
            end
          endcase
        end
        B_DIV: begin
          rem_r <= div_ge ? cur - {1'b0, p_r} : cur;
          q_r   <= {q_r[Q_W-2:0], div_ge};
          if (32'(cnt_r) == Q_W - 1) begin
            src_r   <= SRC_W'({q_r[Q_W-2:0], div_ge});
            root_r  <= '0;
            srem_r  <= '0;
            cnt_r   <= '0;
            state_r <= B_SQRT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        B_SQRT: begin
          if (sq_ge) begin
            srem_r <= SRM_W'(srem_sh - trial);
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            srem_r <= SRM_W'(srem_sh);
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          src_r <= {src_r[SRC_W-3:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == ROOT_W - 1) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            corr_r      <= corr;
            outdeg_r    <= deg_r;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/rolling_pearson_correlation.sv -----
// The front takes one request at a time and is not ready again until it has added it to the
// sums; with the window full it then pushes the window and waits while the queue is full.
// The back end takes one window at a time through the shared 70x18 multiplier, the 33-step
// divider and the 17-step square root; a window with zero variance skips divider and root.
// A two-entry queue buffers the front from the back.
// Reset: rst_n synchronous, active low; window length 20, sums, fill and pointer cleared.
module rolling_pearson_correlation #(
  parameter int MAX_WINDOW = rpc_pkg::MAX_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rpc_pkg::N_W-1:0]      cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rpc_pkg::SAMPLE_W-1:0] in_sample_a,
  input  logic [rpc_pkg::SAMPLE_W-1:0] in_sample_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [rpc_pkg::CORR_W-1:0] out_correlation,
  output logic                         out_degenerate
);

  import rpc_pkg::*;

  rpc_q_stat_t          q_stat;
  logic                 q_push;
  logic                 q_pop;
  rpc_job_t             push_job;
  rpc_job_t             pop_job;
  logic [CORR_W-1:0]    corr;

  // Front: takes requests, keeps the ring and the running sums.
  rpc_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample_a(in_sample_a),
    .in_sample_b(in_sample_b),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  // Queue of full windows awaiting evaluation.
  rpc_fifo #(
    .WIDTH($bits(rpc_job_t)),
    .DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(push_job),
    .pop  (q_pop),
    .rdata(pop_job),
    .stat (q_stat)
  );

  // Back: moments, ratio test and output register.
  rpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_correlation(corr),
    .out_degenerate (out_degenerate)
  );

  assign out_correlation = $signed(corr);

endmodule

// ----- design/rpc_checker.sv -----
module rpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_we,
  input logic [rpc_pkg::N_W-1:0]      cfg_wdata,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [rpc_pkg::SAMPLE_W-1:0] in_sample_a,
  input logic [rpc_pkg::SAMPLE_W-1:0] in_sample_b,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [rpc_pkg::CORR_W-1:0] out_correlation,
  input logic                         out_degenerate
);

  // A result held back by the sink keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_correlation) &&
    $stable(out_degenerate))
    else $error("stalled result changed");

  // No result straight out of reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A degenerate window reports zero correlation.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_correlation == '0)
    else $error("degenerate result not zero");

  // The front is busy after taking a request and does not take another at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !cfg_we |=> !in_ready)
    else $error("request taken on consecutive cycles");

endmodule

bind rolling_pearson_correlation rpc_checker u_rpc_checker (.*);
